[sv/dpeu_pkg.sv]
package dpeu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned RegCnt  = 16;
  localparam int unsigned ImmW    = 8;
  localparam int unsigned FlagW   = 4;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [2:0] FixedHigh = 3'b111;
  localparam logic [1:0] FixedLow  = 2'b00;

  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef enum logic [3:0] {
    OpAnd = 4'h0,
    OpEor = 4'h1,
    OpSub = 4'h2,
    OpRsb = 4'h3,
    OpAdd = 4'h4,
    OpAdc = 4'h5,
    OpSbc = 4'h6,
    OpRsc = 4'h7,
    OpTst = 4'h8,
    OpTeq = 4'h9,
    OpCmp = 4'hA,
    OpCmn = 4'hB,
    OpOrr = 4'hC,
    OpMov = 4'hD,
    OpBic = 4'hE,
    OpMvn = 4'hF
  } alu_op_t;

  typedef struct packed {
    logic                ok;
    logic                imm_sel;
    alu_op_t             op;
    logic                s;
    logic [RegIdxW-1:0]  rn;
    logic [RegIdxW-1:0]  rd;
    logic [RegIdxW-1:0]  rm;
    logic [ImmW-1:0]     imm;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t dec;
  } qword_t;

endpackage

[sv/dpeu_instr_if.sv]
interface dpeu_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

[sv/dpeu_result_if.sv]
interface dpeu_result_if;
  logic        valid;
  logic        ready;
  logic        reg_written;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic [3:0]  flags_nzcv;
  logic        illegal;

  modport source (output valid, output reg_written, output dest_index, output dest_value,
                  output flags_nzcv, output illegal, input ready);
  modport sink   (input valid, input reg_written, input dest_index, input dest_value,
                  input flags_nzcv, input illegal, output ready);
endinterface

[sv/data_processing_execute_unit.sv]
// Data-processing execute unit with NZCV flags.
// Channels: instr carries one 32-bit instruction word per handshake; result
// carries reg_written, dest_index, dest_value, flags_nzcv and illegal, one
// word per accepted instruction, in order. Both use valid/ready.
// Path: an accepted word is written into the queue, then read with its
// operands into the execute slot, then executed into the output register.
// Throughput: one instruction per cycle while result is not stalled,
// back-to-back dependent instructions included; the register file write of
// one instruction bypasses into the operand read of the next, and the flag
// register updates as each flag-setting instruction leaves execute.
// Reset (rst, synchronous): queue, execute slot and output register empty,
// flags zero, every register reads as zero until written.
// When the receiver stalls, the output register holds its word, execute
// holds one more, and the two-entry queue fills; instr.ready drops only when
// the queue is full.
module data_processing_execute_unit (
  input  logic          clk,
  input  logic          rst,
  dpeu_instr_if.sink    instr,
  dpeu_result_if.source result
);

  dpeu_pkg::qword_t push;
  dpeu_pkg::qword_t head;
  logic             full;
  logic             pop;

  dpeu_front u_front (
    .instr (instr),
    .full  (full),
    .push  (push)
  );

  dpeu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .pop  (pop),
    .head (head)
  );

  dpeu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

[sv/dpeu_front.sv]
module dpeu_front (
  dpeu_instr_if.sink     instr,
  input  logic           full,
  output dpeu_pkg::qword_t push
);

  logic [31:0] ir;
  logic        fmt_ok;
  logic        zero_ok;

  assign ir     = instr.instruction;
  assign fmt_ok = (ir[31:29] == dpeu_pkg::FixedHigh) && (ir[27:26] == dpeu_pkg::FixedLow);

  always_comb begin
    if (ir[25]) begin
      zero_ok = (ir[11:8] == 4'd0);
    end else begin
      zero_ok = (ir[11:4] == 8'd0);
    end
  end

  assign instr.ready = !full;

  always_comb begin
    push.valid       = instr.valid && !full;
    push.dec.ok      = fmt_ok && zero_ok;
    push.dec.imm_sel = ir[25];
    push.dec.op      = dpeu_pkg::alu_op_t'(ir[24:21]);
    push.dec.s       = ir[20];
    push.dec.rn      = ir[19:16];
    push.dec.rd      = ir[15:12];
    push.dec.rm      = ir[3:0];
    push.dec.imm     = ir[7:0];
  end

endmodule

[sv/dpeu_queue.sv]
module dpeu_queue (
  input  logic              clk,
  input  logic              rst,
  input  dpeu_pkg::qword_t  push,
  output logic              full,
  input  logic              pop,
  output dpeu_pkg::qword_t  head
);

  dpeu_pkg::dec_t                    slots [dpeu_pkg::QDepth];
  logic [dpeu_pkg::QPtrW-1:0]        wr_ptr;
  logic [dpeu_pkg::QPtrW-1:0]        rd_ptr;
  logic [dpeu_pkg::QCntW-1:0]        count;
  logic                              do_pop;

  assign full       = (count == dpeu_pkg::QCntW'(dpeu_pkg::QDepth));
  assign head.valid = (count != '0);
  assign head.dec   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  function automatic logic [dpeu_pkg::QPtrW-1:0] ptr_inc(input logic [dpeu_pkg::QPtrW-1:0] p);
    if (p == dpeu_pkg::QPtrW'(dpeu_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dpeu_pkg::QCntW'(dpeu_pkg::QDepth))
    else $error("queue count above depth");

endmodule

[sv/dpeu_back.sv]
module dpeu_back (
  input  logic              clk,
  input  logic              rst,
  input  dpeu_pkg::qword_t  head,
  output logic              pop,
  dpeu_result_if.source     result
);

  logic [dpeu_pkg::DataW-1:0] rf_mem [dpeu_pkg::RegCnt];
  logic [dpeu_pkg::RegCnt-1:0] rf_valid;

  logic                        e_valid;
  dpeu_pkg::dec_t              e_dec;
  logic [dpeu_pkg::DataW-1:0]  rn_q;
  logic [dpeu_pkg::DataW-1:0]  rm_q;
  logic                        rn_ok;
  logic                        rm_ok;
  logic [dpeu_pkg::FlagW-1:0]  cond_flags;

  logic                        e_adv;
  logic                        we;
  logic                        fwd_rn;
  logic                        fwd_rm;

  logic [dpeu_pkg::DataW-1:0]  a;
  logic [dpeu_pkg::DataW-1:0]  b;
  logic [dpeu_pkg::DataW-1:0]  x;
  logic [dpeu_pkg::DataW-1:0]  y;
  logic [dpeu_pkg::DataW:0]    sum;
  logic [dpeu_pkg::DataW-1:0]  r;
  logic                        arith;
  logic                        sub;
  logic                        swap;
  logic                        cin;
  logic                        compare;
  logic                        force_upd;
  logic                        c_bit;
  logic                        v_bit;
  logic [dpeu_pkg::FlagW-1:0]  nf;
  logic                        upd;
  logic                        wr;
  logic [dpeu_pkg::FlagW-1:0]  flags_out;

  assign e_adv = e_valid && (!result.valid || result.ready);
  assign pop   = head.valid && (!e_valid || e_adv);

  assign a = rn_ok ? rn_q : '0;
  assign b = e_dec.imm_sel ? {{(dpeu_pkg::DataW - dpeu_pkg::ImmW){1'b0}}, e_dec.imm}
                           : (rm_ok ? rm_q : '0);

  always_comb begin
    arith     = 1'b0;
    sub       = 1'b0;
    swap      = 1'b0;
    cin       = 1'b0;
    compare   = 1'b0;
    force_upd = 1'b0;
    unique case (e_dec.op)
      dpeu_pkg::OpSub: begin
        arith = 1'b1; sub = 1'b1; cin = 1'b1;
      end
      dpeu_pkg::OpRsb: begin
        arith = 1'b1; sub = 1'b1; swap = 1'b1; cin = 1'b1;
      end
      dpeu_pkg::OpAdd: begin
        arith = 1'b1;
      end
      dpeu_pkg::OpAdc: begin
        arith = 1'b1; cin = cond_flags[dpeu_pkg::FlagC]; force_upd = 1'b1;
      end
      dpeu_pkg::OpSbc: begin
        arith = 1'b1; sub = 1'b1; cin = cond_flags[dpeu_pkg::FlagC]; force_upd = 1'b1;
      end
      dpeu_pkg::OpRsc: begin
        arith = 1'b1; sub = 1'b1; swap = 1'b1;
        cin = cond_flags[dpeu_pkg::FlagC]; force_upd = 1'b1;
      end
      dpeu_pkg::OpTst, dpeu_pkg::OpTeq: begin
        compare = 1'b1; force_upd = 1'b1;
      end
      dpeu_pkg::OpCmp: begin
        sub = 1'b1; cin = 1'b1; compare = 1'b1; force_upd = 1'b1;
      end
      dpeu_pkg::OpCmn: begin
        compare = 1'b1; force_upd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign x   = swap ? b : a;
  assign y   = swap ? a : b;
  assign sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{dpeu_pkg::DataW{1'b0}}, cin};

  always_comb begin
    unique case (e_dec.op)
      dpeu_pkg::OpAnd, dpeu_pkg::OpTst: r = a & b;
      dpeu_pkg::OpEor, dpeu_pkg::OpTeq: r = a ^ b;
      dpeu_pkg::OpOrr:                  r = a | b;
      dpeu_pkg::OpMov:                  r = b;
      dpeu_pkg::OpBic:                  r = a & ~b;
      dpeu_pkg::OpMvn:                  r = ~b;
      default:                          r = sum[dpeu_pkg::DataW-1:0];
    endcase
  end

  always_comb begin
    if (arith) begin
      c_bit = sub ? ~sum[dpeu_pkg::DataW] : sum[dpeu_pkg::DataW];
      v_bit = sub ? ((x[dpeu_pkg::DataW-1] ^ y[dpeu_pkg::DataW-1]) &
                     (x[dpeu_pkg::DataW-1] ^ r[dpeu_pkg::DataW-1]))
                  : (~(x[dpeu_pkg::DataW-1] ^ y[dpeu_pkg::DataW-1]) &
                     (x[dpeu_pkg::DataW-1] ^ r[dpeu_pkg::DataW-1]));
    end else begin
      c_bit = 1'b0;
      v_bit = 1'b0;
    end
  end

  assign nf        = {r[dpeu_pkg::DataW-1], (r == '0), c_bit, v_bit};
  assign upd       = e_dec.ok && (e_dec.s || force_upd);
  assign wr        = e_dec.ok && !compare;
  assign flags_out = upd ? nf : cond_flags;

  assign we     = e_adv && wr;
  assign fwd_rn = we && (e_dec.rd == head.dec.rn);
  assign fwd_rm = we && (e_dec.rd == head.dec.rm);

  always_ff @(posedge clk) begin
    if (we) begin
      rf_mem[e_dec.rd] <= r;
    end
    if (pop) begin
      rn_q  <= fwd_rn ? r : rf_mem[head.dec.rn];
      rm_q  <= fwd_rm ? r : rf_mem[head.dec.rm];
      rn_ok <= fwd_rn || rf_valid[head.dec.rn];
      rm_ok <= fwd_rm || rf_valid[head.dec.rm];
      e_dec <= head.dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid   <= '0;
      e_valid    <= 1'b0;
      cond_flags <= '0;
    end else begin
      if (we) begin
        rf_valid[e_dec.rd] <= 1'b1;
      end
      if (pop) begin
        e_valid <= 1'b1;
      end else if (e_adv) begin
        e_valid <= 1'b0;
      end
      if (e_adv && upd) begin
        cond_flags <= nf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (e_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      result.reg_written <= wr;
      result.dest_index  <= wr ? e_dec.rd : '0;
      result.dest_value  <= wr ? r : '0;
      result.flags_nzcv  <= flags_out;
      result.illegal     <= !e_dec.ok;
    end
  end

  a_illegal_no_write: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.illegal |-> !result.reg_written)
    else $error("illegal word reported a register write");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.reg_written |-> (result.dest_index == '0) &&
                                           (result.dest_value == '0))
    else $error("unwritten result carries nonzero destination");

  a_flags_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(e_adv) |-> result.valid && (result.flags_nzcv == cond_flags))
    else $error("reported flags differ from flag register");

  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid && (!e_valid || e_adv))
    else $error("queue popped without a free execute slot");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 30;

  typedef struct packed {
    logic                         reg_written;
    logic [dpeu_pkg::RegIdxW-1:0] dest_index;
    logic [dpeu_pkg::DataW-1:0]   dest_value;
    logic [dpeu_pkg::FlagW-1:0]   flags_nzcv;
    logic                         illegal;
  } retire_t;

  bit   clk;
  logic rst;

  dpeu_instr_if  instr_bus ();
  dpeu_result_if result_bus ();

  data_processing_execute_unit dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_bus),
    .result (result_bus)
  );

  logic [dpeu_pkg::DataW-1:0] gpr [dpeu_pkg::RegCnt];
  logic [dpeu_pkg::FlagW-1:0] nzcv;
  logic                       illegal_st;
  retire_t                    retire_q [$];
  retire_t                    want;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned malformed_sent;
  int unsigned results_checked;
  int unsigned regs_written;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still outstanding", cycle_count,
               retire_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [dpeu_pkg::FlagW-1:0] nz_bits(logic [dpeu_pkg::DataW-1:0] r);
    logic [dpeu_pkg::FlagW-1:0] f;
    f = '0;
    f[dpeu_pkg::FlagN] = r[dpeu_pkg::DataW-1];
    f[dpeu_pkg::FlagZ] = (r == '0);
    return f;
  endfunction

  function automatic logic [dpeu_pkg::FlagW-1:0] sum_flags(logic [dpeu_pkg::DataW-1:0] a,
                                                           logic [dpeu_pkg::DataW-1:0] b,
                                                           logic [dpeu_pkg::DataW-1:0] r);
    logic [dpeu_pkg::FlagW-1:0] f;
    logic                       sa;
    logic                       sb;
    logic                       sr;
    sa = a[dpeu_pkg::DataW-1];
    sb = b[dpeu_pkg::DataW-1];
    sr = r[dpeu_pkg::DataW-1];
    f = nz_bits(r);
    f[dpeu_pkg::FlagC] = (sa & sb) | (~sr & (sa | sb));
    f[dpeu_pkg::FlagV] = ~(sa ^ sb) & (sa ^ sr);
    return f;
  endfunction

  function automatic logic [dpeu_pkg::FlagW-1:0] diff_flags(logic [dpeu_pkg::DataW-1:0] a,
                                                            logic [dpeu_pkg::DataW-1:0] b,
                                                            logic [dpeu_pkg::DataW-1:0] r);
    logic [dpeu_pkg::FlagW-1:0] f;
    logic                       sa;
    logic                       sb;
    logic                       sr;
    sa = a[dpeu_pkg::DataW-1];
    sb = b[dpeu_pkg::DataW-1];
    sr = r[dpeu_pkg::DataW-1];
    f = nz_bits(r);
    f[dpeu_pkg::FlagC] = (~sa & sb) | (sr & (~sa | sb));
    f[dpeu_pkg::FlagV] = (sa ^ sb) & (sa ^ sr);
    return f;
  endfunction

  function automatic retire_t execute_instr(logic [31:0] w);
    logic                       imm;
    dpeu_pkg::alu_op_t          op;
    logic                       ok;
    logic                       wr;
    logic                       upd;
    logic                       cin;
    logic [dpeu_pkg::DataW-1:0] a;
    logic [dpeu_pkg::DataW-1:0] b;
    logic [dpeu_pkg::DataW-1:0] r;
    logic [dpeu_pkg::DataW-1:0] cin_w;
    logic [dpeu_pkg::DataW-1:0] bin_w;
    logic [dpeu_pkg::FlagW-1:0] nf;
    retire_t                    res;
    imm = w[25];
    op  = dpeu_pkg::alu_op_t'(w[24:21]);
    ok  = (w[31:29] == dpeu_pkg::FixedHigh) && (w[27:26] == dpeu_pkg::FixedLow) &&
          (imm ? (w[11:8] == '0) : (w[11:4] == '0));
    res = '0;
    if (!ok) begin
      illegal_st = 1'b1;
      res.flags_nzcv = nzcv;
      res.illegal = illegal_st;
    end else begin
      illegal_st = 1'b0;
      a     = gpr[w[19:16]];
      b     = imm ? {{(dpeu_pkg::DataW-dpeu_pkg::ImmW){1'b0}}, w[7:0]} : gpr[w[3:0]];
      cin   = nzcv[dpeu_pkg::FlagC];
      cin_w = {{(dpeu_pkg::DataW-1){1'b0}}, cin};
      bin_w = {{(dpeu_pkg::DataW-1){1'b0}}, ~cin};
      r     = '0;
      nf    = nzcv;
      wr    = 1'b1;
      upd   = w[20];
      case (op)
        dpeu_pkg::OpAnd: begin r = a & b; nf = nz_bits(r); end
        dpeu_pkg::OpEor: begin r = a ^ b; nf = nz_bits(r); end
        dpeu_pkg::OpSub: begin r = a - b; nf = diff_flags(a, b, r); end
        dpeu_pkg::OpRsb: begin r = b - a; nf = diff_flags(b, a, r); end
        dpeu_pkg::OpAdd: begin r = a + b; nf = sum_flags(a, b, r); end
        dpeu_pkg::OpAdc: begin r = a + b + cin_w; nf = sum_flags(a, b, r); upd = 1'b1; end
        dpeu_pkg::OpSbc: begin r = a - b - bin_w; nf = diff_flags(a, b, r); upd = 1'b1; end
        dpeu_pkg::OpRsc: begin r = b - a - bin_w; nf = diff_flags(b, a, r); upd = 1'b1; end
        dpeu_pkg::OpTst: begin nf = nz_bits(a & b); upd = 1'b1; wr = 1'b0; end
        dpeu_pkg::OpTeq: begin nf = nz_bits(a ^ b); upd = 1'b1; wr = 1'b0; end
        dpeu_pkg::OpCmp: begin nf = nz_bits(a - b); upd = 1'b1; wr = 1'b0; end
        dpeu_pkg::OpCmn: begin nf = nz_bits(a + b); upd = 1'b1; wr = 1'b0; end
        dpeu_pkg::OpOrr: begin r = a | b; nf = nz_bits(r); end
        dpeu_pkg::OpMov: begin r = b; nf = nz_bits(r); end
        dpeu_pkg::OpBic: begin r = a & ~b; nf = nz_bits(r); end
        dpeu_pkg::OpMvn: begin r = ~b; nf = nz_bits(r); end
      endcase
      if (upd) begin
        nzcv = nf;
      end
      if (wr) begin
        gpr[w[15:12]] = r;
      end
      res.reg_written = wr;
      res.dest_index  = wr ? w[15:12] : '0;
      res.dest_value  = wr ? r : '0;
      res.flags_nzcv  = nzcv;
      res.illegal     = illegal_st;
    end
    return res;
  endfunction

  function automatic logic [31:0] dp_word(logic imm, dpeu_pkg::alu_op_t op, logic s,
                                          logic [3:0] rn, logic [3:0] rd, logic [11:0] op2);
    return {dpeu_pkg::FixedHigh, 1'($urandom_range(1)), dpeu_pkg::FixedLow, imm, op, s, rn,
            rd, op2};
  endfunction

  function automatic logic [31:0] dp_imm(dpeu_pkg::alu_op_t op, logic s, logic [3:0] rn,
                                         logic [3:0] rd, logic [7:0] imm8);
    return dp_word(1'b1, op, s, rn, rd, {4'h0, imm8});
  endfunction

  function automatic logic [31:0] dp_reg(dpeu_pkg::alu_op_t op, logic s, logic [3:0] rn,
                                         logic [3:0] rd, logic [3:0] rm);
    return dp_word(1'b0, op, s, rn, rd, {8'h00, rm});
  endfunction

  function automatic logic [31:0] random_dp();
    logic imm;
    imm = 1'($urandom_range(1));
    return dp_word(imm, dpeu_pkg::alu_op_t'($urandom_range(15)), 1'($urandom_range(1)),
                   4'($urandom_range(15)), 4'($urandom_range(15)),
                   imm ? {4'h0, 8'($urandom_range(255))} : {8'h00, 4'($urandom_range(15))});
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatch_count < MaxReports) begin
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, exp_val);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (retire_q.size() == 0) begin
        report_mismatch("unexpected result word", result_bus.dest_value, '0);
      end else begin
        want = retire_q.pop_front();
        results_checked++;
        if (result_bus.reg_written !== want.reg_written)
          report_mismatch("reg_written", 32'(result_bus.reg_written), 32'(want.reg_written));
        if (result_bus.dest_index !== want.dest_index)
          report_mismatch("dest_index", 32'(result_bus.dest_index), 32'(want.dest_index));
        if (result_bus.dest_value !== want.dest_value)
          report_mismatch("dest_value", result_bus.dest_value, want.dest_value);
        if (result_bus.flags_nzcv !== want.flags_nzcv)
          report_mismatch("flags_nzcv", 32'(result_bus.flags_nzcv), 32'(want.flags_nzcv));
        if (result_bus.illegal !== want.illegal)
          report_mismatch("illegal", 32'(result_bus.illegal), 32'(want.illegal));
      end
    end
  end

  task automatic send_word(logic [31:0] w);
    retire_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      instr_bus.valid <= 1'b0;
      instr_bus.instruction <= 32'($urandom);
      @(negedge clk);
    end
    instr_bus.valid <= 1'b1;
    instr_bus.instruction <= w;
    do @(posedge clk); while (!instr_bus.ready);
    res = execute_instr(w);
    retire_q.push_back(res);
    words_sent++;
    if (res.illegal) begin
      malformed_sent++;
    end
    if (res.reg_written) begin
      regs_written++;
    end
  endtask

  task automatic test_operand_extremes();
    send_word(dp_imm(dpeu_pkg::OpMov, 1'b1, 4'h0, 4'h1, 8'hFF));
    send_word(dp_imm(dpeu_pkg::OpMvn, 1'b1, 4'h0, 4'h2, 8'h00));
    send_word(dp_imm(dpeu_pkg::OpMov, 1'b1, 4'h0, 4'h0, 8'h00));
    send_word(dp_reg(dpeu_pkg::OpAdd, 1'b1, 4'h2, 4'h4, 4'h2));
    send_word(dp_reg(dpeu_pkg::OpAdc, 1'b0, 4'h1, 4'h5, 4'h2));
    send_word(dp_imm(dpeu_pkg::OpMov, 1'b0, 4'h0, 4'hF, 8'h55));
    send_word(dp_reg(dpeu_pkg::OpAdd, 1'b1, 4'hF, 4'hF, 4'hF));
  endtask

  task automatic test_opcode_sweep();
    send_word(dp_reg(dpeu_pkg::OpSub, 1'b1, 4'h0, 4'h6, 4'h1));
    send_word(dp_imm(dpeu_pkg::OpSbc, 1'b0, 4'h1, 4'h7, 8'h00));
    send_word(dp_imm(dpeu_pkg::OpRsb, 1'b0, 4'h1, 4'h8, 8'h00));
    send_word(dp_reg(dpeu_pkg::OpRsc, 1'b0, 4'h2, 4'h9, 4'hF));
    send_word(dp_imm(dpeu_pkg::OpAnd, 1'b0, 4'h2, 4'hA, 8'hAA));
    send_word(dp_reg(dpeu_pkg::OpEor, 1'b1, 4'h4, 4'hB, 4'h2));
    send_word(dp_imm(dpeu_pkg::OpOrr, 1'b1, 4'h0, 4'hC, 8'h80));
    send_word(dp_imm(dpeu_pkg::OpBic, 1'b1, 4'h2, 4'hD, 8'hFF));
    send_word(dp_imm(dpeu_pkg::OpTst, 1'b0, 4'h1, 4'h3, 8'h00));
    send_word(dp_reg(dpeu_pkg::OpTeq, 1'b1, 4'h2, 4'h3, 4'h2));
    send_word(dp_imm(dpeu_pkg::OpCmp, 1'b0, 4'h1, 4'h3, 8'hFF));
    send_word(dp_imm(dpeu_pkg::OpCmn, 1'b0, 4'h2, 4'h3, 8'h01));
  endtask

  task automatic test_format_errors();
    send_word(dp_imm(dpeu_pkg::OpMov, 1'b1, 4'h0, 4'h3, 8'h12) & 32'h1FFF_FFFF);
    send_word(dp_imm(dpeu_pkg::OpMov, 1'b1, 4'h0, 4'h3, 8'h12) | 32'h0C00_0000);
    send_word(dp_imm(dpeu_pkg::OpAdd, 1'b1, 4'h1, 4'h3, 8'h01) | 32'h0000_0F00);
    send_word(dp_reg(dpeu_pkg::OpAdd, 1'b1, 4'h1, 4'h3, 4'h1) | 32'h0000_0FF0);
    send_word(dp_reg(dpeu_pkg::OpMov, 1'b1, 4'h0, 4'h3, 4'h2));
  endtask

  task automatic test_random_program(int unsigned count, int unsigned gap_pct);
    logic [31:0] w;
    int unsigned k;
    idle_pct  = gap_pct;
    stall_pct = gap_pct;
    repeat (count) begin
      w = random_dp();
      case ($urandom_range(9))
        0: w = $urandom;
        1: begin
          if ($urandom_range(1)) begin
            k = $urandom_range(4);
            w[(k < 3) ? 29 + k : 23 + k] ^= 1'b1;
          end else if (w[25]) begin
            w[8 + $urandom_range(3)] = 1'b1;
          end else begin
            w[4 + $urandom_range(7)] = 1'b1;
          end
        end
        default: ;
      endcase
      send_word(w);
    end
  endtask

  initial begin
    rst = 1'b1;
    instr_bus.valid = 1'b0;
    instr_bus.instruction = '0;
    result_bus.ready = 1'b0;
    idle_pct = 19;
    stall_pct = 19;
    for (int i = 0; i < dpeu_pkg::RegCnt; i++) begin
      gpr[i] = '0;
    end
    nzcv = '0;
    illegal_st = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_operand_extremes();
    test_opcode_sweep();
    test_format_errors();
    test_random_program(450, 19);
    test_random_program(250, 0);
    test_random_program(400, 19);

    @(negedge clk);
    instr_bus.valid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d instruction words (%0d malformed), %0d register writes",
             words_sent, malformed_sent, regs_written);
    $display("checked %0d results, %0d field mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
